[design/carl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package carl_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int LINEAR_SPAN = 10;

	localparam int CMD_W    = 1;
	localparam int SLOT_W   = 12;
	localparam int OFF_W    = 32;
	localparam int ADDR_W   = 64;
	localparam int SIZE_W   = 32;
	localparam int COUNT_W  = 13;
	localparam int STATUS_W = 2;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;
	localparam int REG_W   = 2;

	localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b1;

	localparam logic [REG_W-1:0] REG_WIN_START = 2'd0;
	localparam logic [REG_W-1:0] REG_WIN_SIZE  = 2'd1;
	localparam logic [REG_W-1:0] REG_MOD_BASE  = 2'd2;
	localparam logic [REG_W-1:0] REG_ENTRIES   = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND   = 2'd0,
		ST_OUTSIDE = 2'd1,
		ST_NONE    = 2'd2
	} carl_status_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  win_start;
		logic [SIZE_W-1:0]  win_size;
		logic [ADDR_W-1:0]  mod_base;
		logic [COUNT_W-1:0] entry_count;
	} carl_cfg_t;

	// controller to datapath
	typedef struct packed {
		logic wr_tbl;
		logic cap;
		logic init;
		logic rd_mid;
		logic bin_upd;
		logic rd_next;
		logic lin_upd;
		logic rd_hi;
		logic res_out;
		logic res_none;
		logic res_cmp;
		logic load_out;
	} carl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic outside;
		logic empty;
		logic bin_more;
		logic lin_more;
		logic rel_lt;
	} carl_sts_t;

endpackage
`default_nettype wire

[design/carl_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
interface carl_req_if;
	import carl_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [SLOT_W-1:0]   slot;
	logic [OFF_W-1:0]    start_offset;
	logic [ADDR_W-1:0]   lookup_address;

	modport source (output valid, output command, output slot, output start_offset,
		output lookup_address, input ready);
	modport sink (input valid, input command, input slot, input start_offset,
		input lookup_address, output ready);
endinterface

interface carl_rsp_if;
	import carl_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   found_index;

	modport source (output valid, output status, output found_index, input ready);
	modport sink (input valid, input status, input found_index, output ready);
endinterface
`default_nettype wire

[design/code_address_range_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | fields                                        | transfer when
// req     | in  | command, slot, start_offset, lookup_address  | req.valid && req.ready
// rsp     | out | status, found_index                           | rsp.valid && rsp.ready
// apb     | in  | paddr, pwdata (64b regs at 8*i)               | psel && penable && pwrite
//
// a table write lands in the table at its transfer; a lookup that misses the window or finds
// the table empty skips the search, else it runs binary steps while the span exceeds 10,
// then linear steps, then a final compare
// the table has one read port: every search step is a registered read then a compare
// one item at a time; req.ready is low from a lookup transfer until its result is loaded
// a result waits in the output register while rsp.ready is low
// reset clears control and the configuration registers, not the table or the datapath registers
module code_address_range_lookup (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [carl_pkg::PADDR_W-1:0] paddr,
	input  wire logic [carl_pkg::PDATA_W-1:0] pwdata,
	output      logic [carl_pkg::PDATA_W-1:0] prdata,
	output      logic                         pready,
	carl_req_if.sink                          req,
	carl_rsp_if.source                        rsp
);
	import carl_pkg::*;

	carl_cfg_t cfg;
	carl_cmd_t cmd;
	carl_sts_t sts;

	// configuration registers; the user writes them only while idle, the block does not enforce it
	carl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: range check, binary steps, linear tail, result hand-off
	carl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_command (req.command),
		.in_ready   (req.ready),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// table memory, search bounds and output register
	carl_dp u_dp (
		.clk            (clk),
		.cfg            (cfg),
		.cmd            (cmd),
		.sts            (sts),
		.slot           (req.slot),
		.start_offset   (req.start_offset),
		.lookup_address (req.lookup_address),
		.status         (rsp.status),
		.found_index    (rsp.found_index)
	);

	// a lookup transfer blocks the input until its result is out
	a_lookup_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.command == CMD_LOOKUP) |=> !req.ready)
		else $error("input taken during a lookup");

	// a table write never produces a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.command == CMD_WRITE && !rsp.valid) |=> !rsp.valid)
		else $error("result appeared after a table write");

	// index is zero unless the entry was found
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_FOUND) |-> (rsp.found_index == '0))
		else $error("nonzero index without a hit");
endmodule
`default_nettype wire

[design/carl_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
module carl_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [carl_pkg::PADDR_W-1:0] paddr,
	input  wire logic [carl_pkg::PDATA_W-1:0] pwdata,
	output      logic [carl_pkg::PDATA_W-1:0] prdata,
	output      logic                         pready,
	output      carl_pkg::carl_cfg_t          cfg
);
	import carl_pkg::*;

	carl_cfg_t       cfg_q;
	logic [REG_W-1:0] reg_idx;
	logic            wr_en;

	assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_W];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_WIN_START: cfg_q.win_start   <= pwdata[ADDR_W-1:0];
				REG_WIN_SIZE:  cfg_q.win_size    <= pwdata[SIZE_W-1:0];
				REG_MOD_BASE:  cfg_q.mod_base    <= pwdata[ADDR_W-1:0];
				REG_ENTRIES:   cfg_q.entry_count <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WIN_START: prdata = PDATA_W'(cfg_q.win_start);
			REG_WIN_SIZE:  prdata = PDATA_W'(cfg_q.win_size);
			REG_MOD_BASE:  prdata = PDATA_W'(cfg_q.mod_base);
			REG_ENTRIES:   prdata = PDATA_W'(cfg_q.entry_count);
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

[design/carl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module carl_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [carl_pkg::CMD_W-1:0] in_command,
	output      logic                       in_ready,
	output      logic                       out_valid,
	input  wire logic                       out_ready,
	input  wire carl_pkg::carl_sts_t        sts,
	output      carl_pkg::carl_cmd_t        cmd
);
	import carl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RANGE,
		S_BIN_RD,
		S_BIN_CMP,
		S_LIN_RD,
		S_LIN_CMP,
		S_FIN_CMP,
		S_RESULT
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_command == CMD_WRITE) begin
						cmd.wr_tbl = 1'b1;
					end else begin
						cmd.cap = 1'b1;
						state_d = S_RANGE;
					end
				end
			end
			S_RANGE: begin
				if (sts.outside) begin
					cmd.res_out = 1'b1;
					state_d     = S_RESULT;
				end else if (sts.empty) begin
					cmd.res_none = 1'b1;
					state_d      = S_RESULT;
				end else begin
					cmd.init = 1'b1;
					state_d  = S_BIN_RD;
				end
			end
			S_BIN_RD: begin
				if (sts.bin_more) begin
					cmd.rd_mid = 1'b1;
					state_d    = S_BIN_CMP;
				end else begin
					state_d = S_LIN_RD;
				end
			end
			S_BIN_CMP: begin
				cmd.bin_upd = 1'b1;
				state_d     = S_BIN_RD;
			end
			S_LIN_RD: begin
				if (sts.lin_more) begin
					cmd.rd_next = 1'b1;
					state_d     = S_LIN_CMP;
				end else begin
					cmd.rd_hi = 1'b1;
					state_d   = S_FIN_CMP;
				end
			end
			S_LIN_CMP: begin
				cmd.lin_upd = 1'b1;
				state_d     = S_LIN_RD;
			end
			S_FIN_CMP: begin
				cmd.res_cmp = 1'b1;
				state_d     = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

[design/carl_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module carl_dp (
	input  wire logic                          clk,
	input  wire carl_pkg::carl_cfg_t           cfg,
	input  wire carl_pkg::carl_cmd_t           cmd,
	output      carl_pkg::carl_sts_t           sts,
	input  wire logic [carl_pkg::SLOT_W-1:0]   slot,
	input  wire logic [carl_pkg::OFF_W-1:0]    start_offset,
	input  wire logic [carl_pkg::ADDR_W-1:0]   lookup_address,
	output      logic [carl_pkg::STATUS_W-1:0] status,
	output      logic [carl_pkg::SLOT_W-1:0]   found_index
);
	import carl_pkg::*;

	logic [OFF_W-1:0]    tbl_mem [TABLE_DEPTH];
	logic [OFF_W-1:0]    rd_data_q;
	logic [IDX_W-1:0]    rd_addr;
	logic                rd_en;
	logic                slot_ok;

	logic [ADDR_W-1:0]   addr_q;
	logic [OFF_W-1:0]    rel_q;
	logic [IDX_W-1:0]    lo_q, hi_q, mid_q;
	logic [IDX_W-1:0]    span;
	logic [IDX_W-1:0]    mid;
	logic [IDX_W-1:0]    hi_init;
	logic [ADDR_W-1:0]   win_end;
	logic                rel_lt;

	carl_status_t        res_status_q;
	logic [IDX_W-1:0]    res_index_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   found_index_q;

	assign slot_ok = (32'(slot) < 32'(TABLE_DEPTH));

	// window end wraps modulo 2^64; the unsigned compare then leaves a wrapped window empty
	assign win_end = cfg.win_start + ADDR_W'(cfg.win_size);
	assign sts.outside = (addr_q < cfg.win_start) || (win_end <= addr_q);
	assign sts.empty   = (cfg.entry_count == '0);

	// counts beyond the table depth are clamped
	assign hi_init = (32'(cfg.entry_count) > 32'(TABLE_DEPTH)) ?
		IDX_W'(TABLE_DEPTH - 1) : IDX_W'(cfg.entry_count - 1'b1);

	assign span         = hi_q - lo_q;
	assign mid          = lo_q + (span >> 1);
	assign sts.bin_more = (32'(span) > 32'(LINEAR_SPAN));
	assign sts.lin_more = (lo_q < hi_q);
	assign rel_lt       = (rel_q < rd_data_q);
	assign sts.rel_lt   = rel_lt;

	assign rd_en = cmd.rd_mid || cmd.rd_next || cmd.rd_hi;
	always_comb begin
		if (cmd.rd_mid) begin
			rd_addr = mid;
		end else if (cmd.rd_next) begin
			rd_addr = lo_q + 1'b1;
		end else begin
			rd_addr = hi_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_tbl && slot_ok) begin
			tbl_mem[IDX_W'(slot)] <= start_offset;
		end
		if (rd_en) begin
			rd_data_q <= tbl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			addr_q <= lookup_address;
		end
		if (cmd.init) begin
			rel_q <= addr_q[OFF_W-1:0] - cfg.mod_base[OFF_W-1:0];
			lo_q  <= '0;
			hi_q  <= hi_init;
		end
		if (cmd.rd_mid) begin
			mid_q <= mid;
		end
		if (cmd.bin_upd) begin
			if (rel_lt) begin
				hi_q <= mid_q - 1'b1;
			end else begin
				lo_q <= mid_q;
			end
		end
		if (cmd.lin_upd) begin
			if (rel_lt) begin
				hi_q <= lo_q;
			end else begin
				lo_q <= lo_q + 1'b1;
			end
		end
		if (cmd.res_out) begin
			res_status_q <= ST_OUTSIDE;
			res_index_q  <= '0;
		end else if (cmd.res_none) begin
			res_status_q <= ST_NONE;
			res_index_q  <= '0;
		end else if (cmd.res_cmp) begin
			res_status_q <= rel_lt ? ST_NONE : ST_FOUND;
			res_index_q  <= rel_lt ? '0 : hi_q;
		end
		if (cmd.load_out) begin
			status_q      <= res_status_q;
			found_index_q <= SLOT_W'(res_index_q);
		end
	end

	assign status      = status_q;
	assign found_index = found_index_q;
endmodule
`default_nettype wire

[tb/carl_answer_checker.sv]
`timescale 1ns / 1ps
module carl_answer_checker
	import carl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	carl_req_if                req,
	carl_rsp_if                rsp,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		carl_status_t      status;
		logic [SLOT_W-1:0] index;
	} answer_t;

	logic [OFF_W-1:0]   starts [TABLE_DEPTH];
	logic [ADDR_W-1:0]  win_start;
	logic [SIZE_W-1:0]  win_size;
	logic [ADDR_W-1:0]  mod_base;
	logic [COUNT_W-1:0] entry_count;
	answer_t            due_answers [$];
	int                 mismatches;

	initial begin
		errors  = 0;
		pending = 0;
	end

	// greatest entry at or below the relative offset, binary then linear search
	function automatic answer_t locate_entry(input logic [ADDR_W-1:0] addr);
		answer_t           ans;
		logic [ADDR_W-1:0] win_end;
		logic [OFF_W-1:0]  rel;
		int unsigned       n;
		int unsigned       lo;
		int unsigned       hi;
		int unsigned       mid;
		int unsigned       k;
		ans.status = ST_NONE;
		ans.index  = '0;
		win_end = win_start + ADDR_W'(win_size);
		if (addr < win_start || win_end <= addr) begin
			ans.status = ST_OUTSIDE;
			return ans;
		end
		rel = OFF_W'(addr - mod_base);
		n = entry_count;
		if (n == 0) return ans;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		lo = 0;
		hi = n - 1;
		while (hi - lo > LINEAR_SPAN) begin
			mid = lo + (hi - lo) / 2;
			if (rel < starts[mid]) hi = mid - 1;
			else lo = mid;
		end
		for (k = lo; k < hi; k++) begin
			if (rel < starts[k + 1]) begin
				hi = k;
				break;
			end
		end
		if (rel >= starts[hi]) begin
			ans.status = ST_FOUND;
			ans.index  = SLOT_W'(hi);
		end
		return ans;
	endfunction

	always @(posedge clk) begin
		answer_t want;
		if (!arst_n) begin
			win_start   = '0;
			win_size    = '0;
			mod_base    = '0;
			entry_count = '0;
			mismatches  = 0;
			due_answers.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3 +: REG_W])
					REG_WIN_START: win_start = pwdata;
					REG_WIN_SIZE:  win_size = pwdata[SIZE_W-1:0];
					REG_MOD_BASE:  mod_base = pwdata;
					REG_ENTRIES:   entry_count = pwdata[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (due_answers.size() == 0) begin
					$display("%0t: unexpected result, expected none, got status %0d index %0d",
						$time, rsp.status, rsp.found_index);
					mismatches++;
				end else begin
					want = due_answers.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, rsp.status);
						mismatches++;
					end
					if (rsp.found_index !== want.index) begin
						$display("%0t: found_index mismatch, expected %0d, got %0d",
							$time, want.index, rsp.found_index);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.command == CMD_WRITE) begin
					if (req.slot < TABLE_DEPTH) starts[req.slot] = req.start_offset;
				end else begin
					due_answers.push_back(locate_entry(req.lookup_address));
				end
			end
		end
		errors  <= mismatches;
		pending <= due_answers.size();
	end

endmodule

[tb/code_address_range_lookup_tb.sv]
`timescale 1ns / 1ps
module code_address_range_lookup_tb;
	import carl_pkg::*;

	// watchdog, far above the slowest legal run
	localparam int CYCLE_LIMIT       = 4_000_000;
	// one long back-pressure stretch on the result side
	localparam int HOLD_CYCLES       = 300;
	// margin after the last lookup answers, before touching registers
	localparam int SETTLE_CYCLES     = 8;
	localparam int DRAIN_CYCLES      = 60;
	localparam int PHASES            = 10;
	localparam int LOOKUPS_PER_PHASE = 20;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// checker verdict inputs
	int                 mismatches;
	int                 open_lookups;

	// stimulus asks once for the long receiver hold, receiver marks it done
	logic               hold_req;
	logic               hold_done;
	int                 gap_burst;

	// stimulus-side copy of the registers and table, only used to aim lookups
	logic [ADDR_W-1:0]  win_start;
	logic [SIZE_W-1:0]  win_size;
	logic [ADDR_W-1:0]  mod_base;
	logic [OFF_W-1:0]   starts_shadow [TABLE_DEPTH];

	carl_req_if req_ch ();
	carl_rsp_if rsp_ch ();

	code_address_range_lookup i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	// watches config writes, request and result transfers; predicts and compares
	carl_answer_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (mismatches),
		.pending (open_lookups)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run as a failure
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	// sender idle gaps: mostly none or short, sometimes long, with gap-free bursts
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (gap_burst > 0) begin
			gap_burst--;
			return 0;
		end
		if (r < 8) begin
			gap_burst = $urandom_range(10, 40);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one item and return at the edge where it transfers;
	// valid stays high so a following item can go back to back
	task automatic offer(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
			input logic [OFF_W-1:0] offset, input logic [ADDR_W-1:0] addr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.command        <= cmd;
		req_ch.slot           <= slot;
		req_ch.start_offset   <= offset;
		req_ch.lookup_address <= addr;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// table write; the unused address field carries noise
	task automatic put(input logic [SLOT_W-1:0] slot, input logic [OFF_W-1:0] value);
		starts_shadow[slot] = value;
		offer(CMD_WRITE, slot, value, {$urandom, $urandom});
	endtask

	// lookup; the unused slot and offset fields carry noise
	task automatic lookup(input logic [ADDR_W-1:0] addr);
		offer(CMD_LOOKUP, SLOT_W'($urandom), $urandom, addr);
	endtask

	// quiet the request side and wait until every lookup has answered
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (open_lookups != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup then access phase; psel stays high so writes can follow back to back
	task automatic apb_write(input logic [REG_W-1:0] idx, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 3'b000});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// reprogram all four registers while the block is idle
	task automatic set_regs(input logic [ADDR_W-1:0] start, input logic [SIZE_W-1:0] size,
			input logic [ADDR_W-1:0] base, input logic [COUNT_W-1:0] count);
		settle();
		apb_write(REG_WIN_START, start);
		apb_write(REG_WIN_SIZE, PDATA_W'(size));
		apb_write(REG_MOD_BASE, base);
		apb_write(REG_ENTRIES, PDATA_W'(count));
		psel    <= 1'b0;
		penable <= 1'b0;
		win_start = start;
		win_size  = size;
		mod_base  = base;
	endtask

	// aim mostly at stored starts and their neighbors, else at window edges, inside it or anywhere
	function automatic logic [ADDR_W-1:0] aim_address(input int n);
		logic [OFF_W-1:0] rel;
		int               pick;
		pick = $urandom_range(0, 9);
		if (n > 0 && pick < 6) begin
			rel = starts_shadow[$urandom_range(0, n - 1)];
			case ($urandom_range(0, 2))
				0: rel = rel - 1'b1;
				1: rel = rel + 1'b1;
				default: ;
			endcase
			return mod_base + ADDR_W'(rel);
		end
		case (pick)
			6: return win_start - 1'b1;
			7: return win_start + ADDR_W'(win_size) - ADDR_W'($urandom_range(0, 1));
			8: return win_start + ADDR_W'($urandom_range(0, win_size));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// result side: random short and long stalls, calm stretches, one long hold
	initial begin
		int stall_left;
		int calm_left;
		int pick;
		stall_left = 0;
		calm_left  = 0;
		hold_done  = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				// the output register fills, the block then stalls its request side
				hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				pick = $urandom_range(0, 99);
				if (calm_left > 0) calm_left--;
				else if (pick < 5) calm_left = $urandom_range(30, 80);
				else if (pick < 30) stall_left = $urandom_range(1, 3);
				else if (pick < 33) stall_left = $urandom_range(15, 50);
			end
		end
	end

	// stimulus
	initial begin
		int                ph;
		int                n;
		int                cnt;
		int                k;
		int                q;
		logic [OFF_W-1:0]  v;
		logic [ADDR_W-1:0] ws;
		logic [ADDR_W-1:0] mb;
		logic [SIZE_W-1:0] wsz;
		logic [ADDR_W-1:0] probe_base;

		arst_n                <= 1'b0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		req_ch.valid          <= 1'b0;
		req_ch.command        <= CMD_WRITE;
		req_ch.slot           <= '0;
		req_ch.start_offset   <= '0;
		req_ch.lookup_address <= '0;
		hold_req              <= 1'b0;
		gap_burst = 0;
		win_start = '0;
		win_size  = '0;
		mod_base  = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset give a zero-size window, so the address is outside
		lookup('0);

		// small window with an empty table: edges outside, inside answers not found
		set_regs(64'h1000, 32'h100, 64'h1000, '0);
		lookup(64'hFFF);
		lookup(64'h1000);
		lookup(64'h10FF);
		lookup(64'h1100);
		lookup('1);

		// window that ends just below the top address, which itself stays outside
		set_regs(64'hFFFF_FFFF_FFFF_FF00, 32'hFF, '0, '0);
		lookup(64'hFFFF_FFFF_FFFF_FFFE);
		lookup('1);

		// window that wraps past the top: every address is outside
		set_regs(64'hFFFF_FFFF_FFFF_FF00, 32'h200, '0, '0);
		lookup(64'hFFFF_FFFF_FFFF_FF00);
		lookup(64'hFFFF_FFFF_FFFF_FFFF);

		// full-depth search kept on its low path: slots 0 and 1 plus every
		// binary midpoint visited while the offset stays below slot 1
		put(SLOT_W'(0), 32'd100);
		put(SLOT_W'(1), 32'd200);
		for (k = 7; k < TABLE_DEPTH; k = 2 * k + 1) begin
			put(SLOT_W'(k), 32'h8000_0000 + OFF_W'(k));
		end

		// full-depth count; offsets stay below slot 1 so only written slots are read
		probe_base = 64'h8000_0000_0000_0000;
		set_regs(probe_base, '1, probe_base, COUNT_W'(TABLE_DEPTH));
		lookup(mod_base + 64'd99);
		lookup(mod_base + 64'd100);
		lookup(mod_base + 64'd199);
		lookup(win_start + ADDR_W'(win_size));

		// count register at its maximum, clipped to the table depth
		set_regs(probe_base, '1, probe_base, '1);
		lookup(mod_base + 64'd0);
		lookup(mod_base + 64'd150);

		// random phases: mostly small sorted tables around the linear/binary boundary,
		// one larger table, a wrapped base, an unsorted prefix, a wrapped window
		for (ph = 0; ph < PHASES; ph++) begin
			ws  = {$urandom, $urandom};
			wsz = $urandom_range(32'h1000_0000, 32'hFFFF_FFFF);
			mb  = ws - ADDR_W'($urandom_range(0, 255));
			n   = $urandom_range(0, 32);
			cnt = n;
			case (ph)
				3: begin
					n   = $urandom_range(48, 72);
					cnt = n;
					wsz = '1;
				end
				5: mb = {$urandom, $urandom};
				7: ws = '1 - ADDR_W'($urandom_range(0, 32'h0FFF_FFFF));
				default: ;
			endcase
			set_regs(ws, wsz, mb, COUNT_W'(cnt));

			// rewrite the searched prefix; one phase leaves it unsorted
			if (n < TABLE_DEPTH) begin
				v = $urandom_range(0, 1000);
				for (k = 0; k < n; k++) begin
					if (ph == 9) v = $urandom;
					else if ($urandom_range(0, 3) != 0) v = v + $urandom_range(1, 4095);
					put(SLOT_W'(k), v);
				end
			end

			if (ph == 0) hold_req <= 1'b1;

			for (q = 0; q < LOOKUPS_PER_PHASE; q++) begin
				if ($urandom_range(0, 15) < 2) put(SLOT_W'($urandom), $urandom);
				else lookup(aim_address(n));
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && open_lookups == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
design/carl_pkg.sv
design/carl_ifs.sv
design/carl_regs.sv
design/carl_ctrl.sv
design/carl_dp.sv
design/code_address_range_lookup.sv
tb/carl_answer_checker.sv
tb/code_address_range_lookup_tb.sv
